>>> rtl/sfr_pkg.sv
package sfr_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HDR1   = 8'b0000_0010,
    PH_HDR2   = 8'b0000_0100,
    PH_LEN    = 8'b0000_1000,
    PH_CMD    = 8'b0001_0000,
    PH_DATA   = 8'b0010_0000,
    PH_CSUM_L = 8'b0100_0000,
    PH_CSUM_H = 8'b1000_0000
  } phase_t;

  localparam logic [2:0] REG_START       = 3'd0;
  localparam logic [2:0] REG_LONG_SECOND = 3'd1;
  localparam logic [2:0] REG_LONG_THIRD  = 3'd2;
  localparam logic [2:0] REG_SHORT_SEC   = 3'd3;
  localparam logic [2:0] REG_LEN_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TIMEOUT     = 3'd5;

  localparam logic [6:0] LIMIT_MAX = 7'd64;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       tx_busy;
    logic [5:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_done;
    logic       short_header;
    logic [7:0] command;
    logic [5:0] length;
    logic [7:0] read_data;
    logic [2:0] parser_state;
  } out_word_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] long_second_byte;
    logic [7:0] long_third_byte;
    logic [7:0] short_second_byte;
    logic [6:0] length_limit;
    logic [7:0] timeout_ticks;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    code = 3'd0;
    case (ph)
      PH_HDR1:   code = 3'd1;
      PH_HDR2:   code = 3'd2;
      PH_LEN:    code = 3'd3;
      PH_CMD:    code = 3'd4;
      PH_DATA:   code = 3'd5;
      PH_CSUM_L: code = 3'd6;
      PH_CSUM_H: code = 3'd7;
      default:   code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/sfr_cfg_regs.sv
module sfr_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output sfr_pkg::cfg_t      cfg
);
  import sfr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte        <= 8'd69;
      cfg_r.long_second_byte  <= 8'd82;
      cfg_r.long_third_byte   <= 8'd84;
      cfg_r.short_second_byte <= 8'd72;
      cfg_r.length_limit      <= 7'd64;
      cfg_r.timeout_ticks     <= 8'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START:       cfg_r.start_byte        <= cfg_data;
        REG_LONG_SECOND: cfg_r.long_second_byte  <= cfg_data;
        REG_LONG_THIRD:  cfg_r.long_third_byte   <= cfg_data;
        REG_SHORT_SEC:   cfg_r.short_second_byte <= cfg_data;
        REG_LEN_LIMIT:   cfg_r.length_limit      <= cfg_data[6:0];
        REG_TIMEOUT:     cfg_r.timeout_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/serial_frame_receiver.sv
// The result word for an accepted input word is registered and presented in the next cycle.
// Throughput: one word per cycle while the output is not stalled; the parser state updates in a single pass.
// Input is taken whenever the output register is empty or being drained.
// Synchronous active-low reset idles the parser, clears the held flag and
// counters and restores register defaults; the payload store is not cleared.
module serial_frame_receiver #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfr_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sfr_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import sfr_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 2) ? $clog2(PAYLOAD_DEPTH) : 1;

  cfg_t cfg;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phase_t      phase_r, phase_nxt;
  logic        short_r, short_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic        held_r, held_nxt;
  logic        done;
  logic        wr_en;

  logic        out_valid_r;
  out_word_t   out_word_r;
  logic        rd_sel_r;
  logic [7:0]  rd_data_r;

  logic [7:0]  mem [PAYLOAD_DEPTH];

  logic        in_fire;
  logic [6:0]  lim;
  logic [15:0] csum;
  logic [8:0]  fill_ext, ridx_ext;
  logic [6:0]  fill_inc;
  logic        rd_hit;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign lim      = (cfg.length_limit > LIMIT_MAX) ? LIMIT_MAX : cfg.length_limit;
  assign csum     = ~sum_r;
  assign fill_ext = {3'b000, fill_r};
  assign ridx_ext = {3'b000, in_word.read_index};
  assign fill_inc = {1'b0, fill_r} + 7'd1;
  assign rd_hit   = (in_word.action == ACT_READ) && (ridx_ext < 9'(PAYLOAD_DEPTH));

  always_comb begin
    phase_nxt = phase_r;
    short_nxt = short_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    idle_nxt  = idle_r;
    held_nxt  = held_r;
    done      = 1'b0;
    wr_en     = 1'b0;
    case (in_word.action)
      ACT_BYTE: begin
        if (held_r || in_word.tx_busy) begin
          phase_nxt = PH_IDLE;
        end else begin
          idle_nxt = 8'd0;
          case (phase_r)
            PH_HDR1: begin
              if (in_word.rx_byte == cfg.short_second_byte) begin
                phase_nxt = PH_LEN;
                short_nxt = 1'b1;
              end else if (in_word.rx_byte == cfg.long_second_byte) begin
                phase_nxt = PH_HDR2;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_HDR2: begin
              short_nxt = 1'b0;
              phase_nxt = (in_word.rx_byte == cfg.long_third_byte) ? PH_LEN : PH_IDLE;
            end
            PH_LEN: begin
              if (in_word.rx_byte == 8'd0 || in_word.rx_byte >= {1'b0, lim}) begin
                phase_nxt = PH_IDLE;
              end else begin
                len_nxt   = in_word.rx_byte[5:0];
                sum_nxt   = {8'd0, in_word.rx_byte};
                phase_nxt = PH_CMD;
              end
            end
            PH_CMD: begin
              cmd_nxt   = in_word.rx_byte;
              fill_nxt  = 6'd0;
              sum_nxt   = sum_r + {8'd0, in_word.rx_byte};
              phase_nxt = PH_DATA;
            end
            PH_DATA: begin
              wr_en     = fill_ext < 9'(PAYLOAD_DEPTH);
              fill_nxt  = fill_inc[5:0];
              sum_nxt   = sum_r + {8'd0, in_word.rx_byte};
              phase_nxt = (fill_inc < {1'b0, len_r}) ? PH_DATA : PH_CSUM_L;
            end
            PH_CSUM_L: begin
              phase_nxt = (in_word.rx_byte == csum[7:0]) ? PH_CSUM_H : PH_IDLE;
            end
            PH_CSUM_H: begin
              if (in_word.rx_byte == csum[15:8]) begin
                held_nxt = 1'b1;
                done     = 1'b1;
              end
              phase_nxt = PH_IDLE;
            end
            default: begin
              phase_nxt = (in_word.rx_byte == cfg.start_byte) ? PH_HDR1 : PH_IDLE;
            end
          endcase
        end
      end
      ACT_TICK: begin
        if (idle_r < cfg.timeout_ticks) idle_nxt = idle_r + 8'd1;
        else phase_nxt = PH_IDLE;
      end
      ACT_RELEASE: begin
        held_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      short_r     <= 1'b0;
      len_r       <= 6'd0;
      cmd_r       <= 8'd0;
      fill_r      <= 6'd0;
      sum_r       <= 16'd0;
      idle_r      <= 8'd0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        short_r <= short_nxt;
        len_r   <= len_nxt;
        cmd_r   <= cmd_nxt;
        fill_r  <= fill_nxt;
        sum_r   <= sum_nxt;
        idle_r  <= idle_nxt;
        held_r  <= held_nxt;
      end
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result word fields; read data comes from the store's read register, zeroed unless the read index hit the store
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r.frame_ready  <= held_nxt;
      out_word_r.frame_done   <= done;
      out_word_r.short_header <= short_nxt;
      out_word_r.command      <= cmd_nxt;
      out_word_r.length       <= len_nxt;
      out_word_r.read_data    <= 8'd0;
      out_word_r.parser_state <= phase_code(phase_nxt);
      rd_sel_r                <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) mem[fill_ext[AW-1:0]] <= in_word.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (in_fire) rd_data_r <= mem[ridx_ext[AW-1:0]];
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_word           = out_word_r;
    out_word.read_data = rd_sel_r ? rd_data_r : 8'd0;
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parser phase not one-hot");

  a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_done |->
      out_word.frame_ready && out_word.parser_state == phase_code(PH_IDLE))
    else $error("frame done without held frame");

  a_blocked_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.action == ACT_BYTE && held_r |=> phase_r == PH_IDLE && held_r)
    else $error("byte while frame held did not reset parser");

  a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !(in_word.action == ACT_BYTE && phase_r == PH_CSUM_H) |=> !out_word_r.frame_done)
    else $error("frame done outside checksum high byte");

endmodule
